/* rtl/fnl_pkg.sv */
// Shared types, constants and helper functions of the face normal lighting pipeline.
package fnl_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_LIGHT_X = 2'd0;
  localparam logic [1:0] CFG_LIGHT_Y = 2'd1;
  localparam logic [1:0] CFG_LIGHT_Z = 2'd2;

  // Fixed-point constants
  localparam int ROT_SHIFT     = 12;
  localparam int FRONT_SHIFT   = 8;
  localparam int REVERSE_SHIFT = 10;
  localparam int SCALE_SHIFT   = 12;
  localparam int BOOST_KNEE    = 1472;
  localparam int BOOST_SHIFT   = 3;
  localparam int CHAN_MAX      = 4095;
  localparam int SAT_MAX       = 32767;
  localparam int SAT_MIN       = -32768;

  // Widths
  localparam int ROT_PROD_W = 24;  // 16b entry x 8b normal byte
  localparam int ROT_SUM_W  = 26;  // three products
  localparam int LMAC_W     = 34;  // three 16x16 products
  localparam int FACTOR_W   = 26;  // dot product after the 8/10 shift
  localparam int SPROD_W    = 39;  // factor x 12-bit scale
  localparam int BOOST_W    = 27;
  localparam int BADD_W     = 30;
  localparam int LIN_W      = 32;

  // Side data that rides along the rotation stages
  typedef struct packed {
    logic        rev;
    logic [31:0] base;
    logic [23:0] scale;
  } fnl_side_t;

  // Rotated normal, element 0 is x
  typedef logic [2:0][15:0] rot_vec_t;

  // Saturate a shifted row sum to signed 16 bits
  function automatic logic [15:0] sat16(input logic signed [ROT_SUM_W-1:0] v);
    logic [15:0] res;
    if (v < ROT_SUM_W'(SAT_MIN)) begin
      res = 16'h8000;
    end else if (v > ROT_SUM_W'(SAT_MAX)) begin
      res = 16'h7fff;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  // Clamp a 12-bit-scaled channel to 0..4095 and drop the low nibble
  function automatic logic [7:0] chan_out(input logic signed [LIN_W-1:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > LIN_W'(CHAN_MAX)) begin
      res = 8'hff;
    end else begin
      res = v[11:4];
    end
    return res;
  endfunction

endpackage

/* rtl/face_normal_lighting_unit.sv */
// Top level of the per-face flat lighting pipeline.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, matrix rows, normal,     | input
//          | reverse flag, light base, light scale           |
//  out     | out_valid_o/out_ready_i, face_rgb_o             | output
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i| input
//
// Six register stages: products, rotation, light products, dot/shift,
// scale and boost, clamp and pack. One face per cycle while the output is not stalled.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and a stall at the output backs up without loss.
// Reset clears the valid bits and the light registers; cfg writes always land.
module face_normal_lighting_unit import fnl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [47:0] matrix_row_a_i,
  input  logic [47:0] matrix_row_b_i,
  input  logic [47:0] matrix_row_c_i,
  input  logic [31:0] normal_word_i,
  input  logic        reverse_facing_i,
  input  logic [31:0] light_base_i,
  input  logic [23:0] light_scale_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] face_rgb_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Light row registers
  logic signed [15:0] light_q [3];

  fnl_side_t side_in, side_r;
  rot_vec_t  rot_r;
  logic      rot_valid;
  logic      rot_ready;

  // Stage 3
  logic signed [31:0] mprod_d [3];
  logic signed [31:0] mprod_q [3];
  fnl_side_t side3_q;
  logic      s3_valid_q, s3_adv;

  // Stage 4
  logic signed [LMAC_W-1:0]   mac;
  logic signed [LMAC_W-1:0]   mac_sh;
  logic signed [FACTOR_W-1:0] factor_d, factor_q;
  logic [31:0]                base_h;
  logic [2:0][7:0]            base4_d, base4_q, scl4_q;
  logic      s4_valid_q, s4_adv;

  // Stage 5
  logic signed [SPROD_W-1:0] sprod_d [3];
  logic signed [SPROD_W-1:0] sprod_q [3];
  logic signed [BOOST_W-1:0] boost;
  logic signed [BADD_W-1:0]  badd_d, badd_q;
  logic [2:0][7:0]           base5_q;
  logic      s5_valid_q, s5_adv;

  // Stage 6 (output register)
  logic signed [LIN_W-1:0] lin [3];
  logic [23:0] face_rgb_d, face_rgb_q;
  logic        out_valid_q, out_adv;

  // Config transfer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q[0] <= '0;
      light_q[1] <= '0;
      light_q[2] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LIGHT_X: light_q[0] <= cfg_data_i;
        CFG_LIGHT_Y: light_q[1] <= cfg_data_i;
        CFG_LIGHT_Z: light_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Rotation stages
  assign side_in = '{rev: reverse_facing_i, base: light_base_i, scale: light_scale_i};

  fnl_rotate u_rotate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .row_a_i  (matrix_row_a_i),
    .row_b_i  (matrix_row_b_i),
    .row_c_i  (matrix_row_c_i),
    .normal_i (normal_word_i),
    .side_i   (side_in),
    .valid_o  (rot_valid),
    .ready_i  (rot_ready),
    .rot_o    (rot_r),
    .side_o   (side_r)
  );

  // Advance chain
  assign out_adv   = !out_valid_q || out_ready_i;
  assign s5_adv    = !s5_valid_q || out_adv;
  assign s4_adv    = !s4_valid_q || s5_adv;
  assign s3_adv    = !s3_valid_q || s4_adv;
  assign rot_ready = s3_adv;

  // Stage 3: light row times rotated normal
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mprod_d[i] = light_q[i] * $signed(rot_r[i]);
    end
  end

  // Stage 4: dot product, facing shift, base halving
  always_comb begin
    mac      = LMAC_W'(mprod_q[0]) + LMAC_W'(mprod_q[1]) + LMAC_W'(mprod_q[2]);
    mac_sh   = side3_q.rev ? (mac >>> REVERSE_SHIFT) : (mac >>> FRONT_SHIFT);
    factor_d = mac_sh[FACTOR_W-1:0];
    base_h   = side3_q.rev ? (side3_q.base >> 1) : side3_q.base;
    base4_d  = base_h[23:0];
  end

  // Stage 5: scaled light and boost
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sprod_d[i] = SPROD_W'(factor_q) * SPROD_W'($signed({1'b0, scl4_q[i], 4'b0}));
    end
    boost  = BOOST_W'(factor_q) - BOOST_W'(BOOST_KNEE);
    badd_d = (boost > 0) ? (BADD_W'(boost) <<< BOOST_SHIFT) : '0;
  end

  // Stage 6: sum, clamp and pack
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lin[i] = $signed({20'd0, base5_q[i], 4'd0})
             + LIN_W'(sprod_q[i] >>> SCALE_SHIFT) + LIN_W'(badd_q);
      face_rgb_d[8*i +: 8] = chan_out(lin[i]);
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s3_adv)  s3_valid_q  <= rot_valid;
      if (s4_adv)  s4_valid_q  <= s3_valid_q;
      if (s5_adv)  s5_valid_q  <= s4_valid_q;
      if (out_adv) out_valid_q <= s5_valid_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      mprod_q <= mprod_d;
      side3_q <= side_r;
    end
    if (s4_adv) begin
      factor_q <= factor_d;
      base4_q  <= base4_d;
      scl4_q   <= side3_q.scale;
    end
    if (s5_adv) begin
      sprod_q <= sprod_d;
      badd_q  <= badd_d;
      base5_q <= base4_q;
    end
    if (out_adv) begin
      face_rgb_q <= face_rgb_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign face_rgb_o  = face_rgb_q;

  // With the output empty the whole pipe moves, so the input is open
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input blocked with empty output");

  // A result only appears from a valid stage 5 item
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s5_valid_q))
    else $error("result without source item");

  // A stalled stage 4 item is neither dropped nor altered
  a_s4_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_valid_q && !s5_adv) |=> (s4_valid_q && $stable(factor_q)))
    else $error("stage 4 item lost while stalled");

endmodule

/* rtl/fnl_rotate.sv */
// Two-stage pipeline that rotates the packed normal by the 3x3 matrix.
module fnl_rotate import fnl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [47:0] row_a_i,
  input  logic [47:0] row_b_i,
  input  logic [47:0] row_c_i,
  input  logic [31:0] normal_i,
  input  fnl_side_t   side_i,
  output logic        valid_o,
  input  logic        ready_i,
  output rot_vec_t    rot_o,
  output fnl_side_t   side_o
);

  logic [2:0][47:0] rows;
  logic signed [7:0] nrm [3];

  logic signed [ROT_PROD_W-1:0] prod_d [3][3];
  logic signed [ROT_PROD_W-1:0] prod_q [3][3];
  fnl_side_t side1_q;
  logic      s1_valid_q;
  logic      s1_adv;

  logic signed [ROT_SUM_W-1:0] sum [3];
  rot_vec_t  rot_d, rot_q;
  fnl_side_t side2_q;
  logic      s2_valid_q;
  logic      s2_adv;

  assign rows   = {row_c_i, row_b_i, row_a_i};
  assign nrm[0] = $signed(normal_i[23:16]);
  assign nrm[1] = $signed(normal_i[15:8]);
  assign nrm[2] = $signed(normal_i[31:24]);

  // Per-stage advance: a stage moves when empty or when the next one moves
  assign s2_adv  = !s2_valid_q || ready_i;
  assign s1_adv  = !s1_valid_q || s2_adv;
  assign ready_o = s1_adv;

  // Stage 1: nine partial products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(rows[r][16*c +: 16]) * nrm[c];
      end
    end
  end

  // Stage 2: row sums, shift and saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = ROT_SUM_W'(prod_q[r][0]) + ROT_SUM_W'(prod_q[r][1])
             + ROT_SUM_W'(prod_q[r][2]);
      rot_d[r] = sat16(sum[r] >>> ROT_SHIFT);
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= valid_i;
      if (s2_adv) s2_valid_q <= s1_valid_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      prod_q  <= prod_d;
      side1_q <= side_i;
    end
    if (s2_adv) begin
      rot_q   <= rot_d;
      side2_q <= side1_q;
    end
  end

  assign valid_o = s2_valid_q;
  assign rot_o   = rot_q;
  assign side_o  = side2_q;

  // A held output item keeps its data
  a_hold_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !ready_i) |=> (s2_valid_q && $stable(rot_q)))
    else $error("rotated normal changed while stalled");

  // An item can only appear at stage 2 from stage 1
  a_s2_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s2_valid_q) |-> $past(s1_valid_q))
    else $error("stage 2 valid without source");

  // Empty output means stage 1 can take an item
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_valid_q |-> ready_o)
    else $error("rotate stalled with empty output");

endmodule

/* dv/face_normal_lighting_unit_test.sv */
// Self-checking testbench of the per-face flat lighting pipeline.
`timescale 1ns / 1ps

module face_normal_lighting_unit_test import fnl_pkg::*; ();

  localparam logic [1:0] CFG_SPARE    = 2'd3;  // index past the register list
  localparam int         IDLE_LIMIT   = 2000;  // cycles without any transfer
  localparam int         TAIL_CYCLES  = 20;    // settle time after the last result
  localparam int         REPORT_MAX   = 10;
  localparam int         PHASE_FACES  = 400;
  localparam int         PHASE_COUNT  = 5;

  // One face as it crosses the input channel
  typedef struct packed {
    logic [47:0] row_a;
    logic [47:0] row_b;
    logic [47:0] row_c;
    logic [31:0] normal;
    logic        rev;
    logic [31:0] base;
    logic [23:0] scale;
  } face_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [47:0] matrix_row_a_i;
  logic [47:0] matrix_row_b_i;
  logic [47:0] matrix_row_c_i;
  logic [31:0] normal_word_i;
  logic        reverse_facing_i;
  logic [31:0] light_base_i;
  logic [23:0] light_scale_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [23:0] face_rgb_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // Light row as the block should hold it
  logic signed [15:0] light_weight [3];
  logic [23:0]        expected_rgb_q [$];

  int unsigned fail_count;
  int unsigned face_count;
  int unsigned reverse_count;
  int unsigned checked_count;
  int unsigned cfg_write_count;
  int unsigned idle_cycles;

  face_normal_lighting_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .matrix_row_a_i   (matrix_row_a_i),
    .matrix_row_b_i   (matrix_row_b_i),
    .matrix_row_c_i   (matrix_row_c_i),
    .normal_word_i    (normal_word_i),
    .reverse_facing_i (reverse_facing_i),
    .light_base_i     (light_base_i),
    .light_scale_i    (light_scale_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .face_rgb_o       (face_rgb_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Expected packed color of one face under the current light row
  function automatic logic [23:0] predict_face_rgb(face_t f);
    logic [47:0] rows [3];
    longint      nrm [3];
    longint      rot [3];
    longint      sum;
    longint      mac;
    longint      factor;
    longint      boost;
    longint      lin;
    logic [31:0] base;
    logic [23:0] rgb;
    rows[0] = f.row_a;
    rows[1] = f.row_b;
    rows[2] = f.row_c;
    nrm[0] = longint'($signed(f.normal[23:16]));
    nrm[1] = longint'($signed(f.normal[15:8]));
    nrm[2] = longint'($signed(f.normal[31:24]));
    // rotate, shift and saturate each row
    for (int r = 0; r < 3; r++) begin
      sum = 0;
      for (int c = 0; c < 3; c++) begin
        sum += longint'($signed(rows[r][16*c +: 16])) * nrm[c];
      end
      sum = sum >>> ROT_SHIFT;
      if (sum < SAT_MIN) sum = SAT_MIN;
      if (sum > SAT_MAX) sum = SAT_MAX;
      rot[r] = sum;
    end
    mac = longint'(light_weight[0]) * rot[0] + longint'(light_weight[1]) * rot[1] +
          longint'(light_weight[2]) * rot[2];
    factor = mac >>> (f.rev ? REVERSE_SHIFT : FRONT_SHIFT);
    base = f.rev ? (f.base >> 1) : f.base;
    boost = factor - BOOST_KNEE;
    // per channel: base plus scaled light plus boost, clamped to 12 bits
    for (int ch = 0; ch < 3; ch++) begin
      lin = longint'({base[8*ch +: 8], 4'h0});
      lin += (factor * longint'({f.scale[8*ch +: 8], 4'h0})) >>> SCALE_SHIFT;
      if (boost > 0) lin += boost << BOOST_SHIFT;
      if (lin < 0) lin = 0;
      if (lin > CHAN_MAX) lin = CHAN_MAX;
      rgb[8*ch +: 8] = lin[11:4];
    end
    return rgb;
  endfunction

  // Drive one face and record its expected color on transfer
  task automatic send_face(face_t f);
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    matrix_row_a_i   <= f.row_a;
    matrix_row_b_i   <= f.row_b;
    matrix_row_c_i   <= f.row_c;
    normal_word_i    <= f.normal;
    reverse_facing_i <= f.rev;
    light_base_i     <= f.base;
    light_scale_i    <= f.scale;
    do @(posedge clk_i); while (!in_ready_o);
    expected_rgb_q.insert(expected_rgb_q.size(), predict_face_rgb(f));
    face_count++;
    if (f.rev) reverse_count++;
  endtask

  task automatic idle_sender(int unsigned cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stop sending and wait until every face has come back
  task automatic wait_faces_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_rgb_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_light_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LIGHT_X: light_weight[0] = data;
      CFG_LIGHT_Y: light_weight[1] = data;
      CFG_LIGHT_Z: light_weight[2] = data;
      default: ;  // no register behind this index
    endcase
    cfg_write_count++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [47:0] random_row(bit narrow);
    logic [47:0] row;
    int          e;
    for (int c = 0; c < 3; c++) begin
      e = int'($urandom_range(0, 8192)) - 4096;
      row[16*c +: 16] = narrow ? e[15:0] : 16'($urandom);
    end
    return row;
  endfunction

  // Zero light row: the color is the base alone, with reverse halving
  task automatic test_reset_lighting();
    face_t f;
    f = '0;
    f.base = 32'hffff_ffff;
    send_face(f);
    f.rev = 1'b1;
    send_face(f);
    f.base = 32'h0101_0100;  // low bit of each next byte lands in bit 7
    send_face(f);
    f.row_a  = 48'({$urandom, $urandom});
    f.row_b  = 48'({$urandom, $urandom});
    f.row_c  = 48'({$urandom, $urandom});
    f.normal = $urandom;
    f.scale  = 24'hffffff;
    f.rev    = 1'b0;
    send_face(f);
    wait_faces_drained();
  endtask

  // Extreme light weights and matrices, plus a write to the spare index
  task automatic test_light_extremes();
    face_t f;
    write_light_reg(CFG_LIGHT_X, 16'h7fff);
    write_light_reg(CFG_LIGHT_Y, 16'h8000);
    write_light_reg(CFG_LIGHT_Z, 16'h7fff);
    write_light_reg(CFG_SPARE, 16'h1234);
    f.row_a  = {3{16'h7fff}};
    f.row_b  = {3{16'h7fff}};
    f.row_c  = {3{16'h7fff}};
    f.normal = 32'h7f7f_7fff;
    f.rev    = 1'b0;
    f.base   = 32'h00ff_00ff;
    f.scale  = 24'hffffff;
    send_face(f);
    f.rev = 1'b1;
    send_face(f);
    f.row_a  = {3{16'h8000}};
    f.row_b  = {3{16'h8000}};
    f.row_c  = {3{16'h8000}};
    f.normal = 32'h8080_8000;
    send_face(f);
    f.row_b  = {3{16'h7fff}};
    f.normal = 32'h807f_7f00;  // negative sums in some rows
    f.rev    = 1'b0;
    send_face(f);
    wait_faces_drained();
  endtask

  // Weights around the boost knee, and a negative factor clamped to zero
  task automatic test_boost_knee();
    face_t       f;
    logic [15:0] weights [4];
    weights = '{16'd371, 16'd372, 16'd378, 16'd1500};
    write_light_reg(CFG_LIGHT_Y, 16'd0);
    write_light_reg(CFG_LIGHT_Z, 16'd0);
    f.row_a = {16'h0000, 16'h0000, 16'h7fff};
    f.row_b = {16'h0000, 16'h7fff, 16'h0000};
    f.row_c = {16'h7fff, 16'h0000, 16'h0000};
    f.base  = 32'h0040_2010;
    f.scale = 24'h80c0ff;
    foreach (weights[i]) begin
      wait_faces_drained();
      write_light_reg(CFG_LIGHT_X, weights[i]);
      f.normal = {8'h00, 8'h7f, 8'h00, 8'($urandom)};  // low byte is unused
      f.rev    = 1'b0;
      send_face(f);
      f.rev = 1'b1;
      send_face(f);
    end
    f.normal = 32'h0080_0000;
    f.base   = 32'h0000_0000;
    f.scale  = 24'hffffff;
    f.rev    = 1'b0;
    send_face(f);
    wait_faces_drained();
  endtask

  // Random faces in bursts under several light rows
  task automatic test_random_faces();
    face_t       f;
    int unsigned span;
    int unsigned burst;
    int unsigned sent;
    int          w;
    bit          narrow;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_faces_drained();
      case ($urandom_range(0, 3))
        0: span = 64;
        1: span = 512;
        2: span = 2048;
        default: span = 32767;
      endcase
      for (int r = 0; r < 3; r++) begin
        w = int'($urandom_range(0, 2 * span)) - int'(span);
        write_light_reg(2'(r), w[15:0]);
      end
      sent = 0;
      while (sent < PHASE_FACES) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && sent < PHASE_FACES; b++) begin
          // halfway through, hold off until the pipeline is empty
          if (sent == PHASE_FACES / 2) wait_faces_drained();
          narrow   = ($urandom_range(0, 9) < 7);
          f.row_a  = random_row(narrow);
          f.row_b  = random_row(narrow);
          f.row_c  = random_row(narrow);
          f.normal = $urandom;
          f.rev    = 1'($urandom_range(0, 1));
          f.base   = $urandom;
          f.scale  = 24'($urandom);
          send_face(f);
          sent++;
        end
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
      end
    end
    wait_faces_drained();
  endtask

  // Receiver backpressure: free running, random, sparse and long stalls
  initial begin
    int unsigned mode;
    int unsigned span;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      for (int k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (k % 4 == 0);
          default: out_ready_i <= (k % 24 >= 20);
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    logic [23:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rgb_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result face_rgb=%06h at %0t", face_rgb_o, $realtime);
      end else begin
        want = expected_rgb_q.pop_front();
        checked_count++;
        if (face_rgb_o !== want) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("face_rgb expected %06h got %06h at %0t", want, face_rgb_o, $realtime);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d faces still expected", expected_rgb_q.size());
      $display("face_normal_lighting_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    matrix_row_a_i   = '0;
    matrix_row_b_i   = '0;
    matrix_row_c_i   = '0;
    normal_word_i    = '0;
    reverse_facing_i = 1'b0;
    light_base_i     = '0;
    light_scale_i    = '0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CFG_LIGHT_X;
    cfg_data_i       = '0;
    light_weight     = '{3{16'sd0}};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_lighting();
    test_light_extremes();
    test_boost_knee();
    test_random_faces();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("sent %0d faces (%0d reverse facing), checked %0d colors", face_count,
             reverse_count, checked_count);
    $display("light row written %0d times, extremes, knee and spare index included",
             cfg_write_count);
    if (fail_count == 0 && expected_rgb_q.size() == 0) begin
      $display("face_normal_lighting_unit: match");
    end else begin
      $display("%0d failures, %0d faces never returned", fail_count, expected_rgb_q.size());
      $display("face_normal_lighting_unit: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/fnl_pkg.sv
rtl/fnl_rotate.sv
rtl/face_normal_lighting_unit.sv
dv/face_normal_lighting_unit_test.sv
